// File: design/ssr_pkg.sv
// Shared types and constants for the span shift-reduce stack.
// Used by ssr_ctrl, ssr_datapath, span_shift_reduce_stack and tb_top; depends on nothing.
package ssr_pkg;

  localparam int POS_W           = 8;
  localparam int DIST_W          = 10;
  localparam int STACK_DEPTH_DEF = 16;
  // Positions are reduced modulo this count; it must be a power of two.
  localparam int POSITION_COUNT  = 256;

  localparam logic [DIST_W-1:0] DIST_POS_ONE = DIST_W'(1);
  localparam logic [DIST_W-1:0] DIST_NEG_ONE = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming span
    logic first;   // push onto an empty stack, distance = start + 1
    logic eval;    // compare with the top span, pop, push, or drop when full
    logic absorb;  // pop the span below into the merged span
    logic push;    // push the merged span
    logic emit;    // load the output register
  } ssr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic adj;     // distance to the top span is +1 or -1
    logic abut;    // merged span abuts the span below on either side
  } ssr_stat_t;

endpackage

// File: design/ssr_ctrl.sv
// Sequencer of the span shift-reduce stack: steps one transaction through
// first-push or evaluate, merge and result phases. Depends on ssr_pkg.
module ssr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  output logic              m_tvalid,
  input  ssr_pkg::ssr_stat_t stat,
  output ssr_pkg::ssr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    FIRST,
    EVAL,
    MERGE,
    RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = stat.empty ? FIRST : EVAL;
        end
      end
      FIRST: begin
        cmd.first  = 1'b1;
        state_next = RESULT;
      end
      EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.adj ? MERGE : RESULT;
      end
      MERGE: begin
        if (!stat.empty && stat.abut) begin
          cmd.absorb = 1'b1;
        end else begin
          cmd.push   = 1'b1;
          state_next = RESULT;
        end
      end
      RESULT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: design/ssr_datapath.sv
// Datapath of the span shift-reduce stack: span registers, stack memory,
// distance and abut compares, output register. Depends on ssr_pkg.
module ssr_datapath #(
  parameter  int STACK_DEPTH = ssr_pkg::STACK_DEPTH_DEF,
  localparam int CW          = $clog2(STACK_DEPTH + 1),
  localparam int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ssr_pkg::POS_W-1:0]         in_start,
  input  logic [ssr_pkg::POS_W-1:0]         in_end,
  input  ssr_pkg::ssr_cmd_t                 cmd,
  output ssr_pkg::ssr_stat_t                stat,
  output logic signed [ssr_pkg::DIST_W-1:0] res_distance,
  output logic [CW-1:0]                     res_depth,
  output logic                              res_overflow
);

  localparam int PW = ssr_pkg::POS_W;
  localparam int DW = ssr_pkg::DIST_W;

  logic [PW-1:0]   cur_start;
  logic [PW-1:0]   cur_end;
  logic [2*PW-1:0] mem [STACK_DEPTH];
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]   top_start;
  logic [PW-1:0]   top_end;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   rd_idx;
  logic            we;
  logic [DW-1:0]   dist_calc;
  logic [DW-1:0]   step_dist;
  logic            ovf;
  logic            adj;
  logic            abut_lo;
  logic            abut_hi;
  logic [PW-1:0]   red_start;
  logic [PW-1:0]   red_end;

  assign red_start = PW'(32'(in_start) % ssr_pkg::POSITION_COUNT);
  assign red_end   = PW'(32'(in_end) % ssr_pkg::POSITION_COUNT);

  assign top_start = rd_data[PW-1:0];
  assign top_end   = rd_data[2*PW-1:PW];

  // Two's complement difference, wrapped to the distance width
  assign dist_calc = (cur_start > top_start) ? (DW'(cur_start) - DW'(top_end))
                                             : (DW'(cur_end) - DW'(top_start));
  assign adj = (dist_calc == ssr_pkg::DIST_POS_ONE) ||
               (dist_calc == ssr_pkg::DIST_NEG_ONE);

  assign abut_lo = ((PW + 1)'(cur_start) == (PW + 1)'(top_end) + (PW + 1)'(1));
  assign abut_hi = ((PW + 1)'(top_start) == (PW + 1)'(cur_end) + (PW + 1)'(1));

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(STACK_DEPTH));
  assign stat.adj   = adj;
  assign stat.abut  = abut_lo || abut_hi;

  always_comb begin
    we         = 1'b0;
    count_next = count;
    if (cmd.first || cmd.push) begin
      we         = 1'b1;
      count_next = count + CW'(1);
    end
    if (cmd.eval) begin
      if (adj) begin
        count_next = count - CW'(1);
      end else if (!stat.full) begin
        we         = 1'b1;
        count_next = count + CW'(1);
      end
    end
    if (cmd.absorb) begin
      count_next = count - CW'(1);
    end
  end

  // Read the entry that will be on top next cycle
  assign rd_idx = count_next - CW'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[AW-1:0]] <= {cur_end, cur_start};
    end
    rd_data <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_start <= red_start;
      cur_end   <= red_end;
    end
    if (cmd.first) begin
      step_dist <= DW'(cur_start) + DW'(1);
      ovf       <= 1'b0;
    end
    if (cmd.eval) begin
      step_dist <= dist_calc;
      ovf       <= !adj && stat.full;
      if (adj) begin
        if (dist_calc == ssr_pkg::DIST_POS_ONE) begin
          cur_start <= top_start;
        end else begin
          cur_end <= top_end;
        end
      end
    end
    if (cmd.absorb) begin
      if (abut_lo) begin
        cur_start <= top_start;
      end else begin
        cur_end <= top_end;
      end
    end
    if (cmd.emit) begin
      res_distance <= step_dist;
      res_depth    <= count;
      res_overflow <= ovf;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_absorb_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.absorb |-> !stat.empty && stat.abut)
    else $error("absorb without an abutting span below");

  a_plain_push: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && !adj && !stat.full |=> count == $past(count) + CW'(1))
    else $error("unmerged push did not grow the stack");
`endif

endmodule

// File: design/span_shift_reduce_stack.sv
// Top level of the span shift-reduce stack: joins ssr_ctrl and ssr_datapath.
// Depends on ssr_pkg, ssr_ctrl and ssr_datapath.
//
// Usage:
//   s_* channel takes one span per transaction: start and end word positions.
//   m_* channel returns one result per span: signed distance to the previous
//   top span (start + 1 on an empty stack), stack depth after the step, and an
//   overflow flag set when an unmerged span hit a full stack and was dropped.
//   A span at distance +1 or -1 pops and merges with the top, then keeps
//   absorbing abutting spans below before it is pushed.
// Sequencing:
//   One span at a time. An unmerged span goes from acceptance through the
//   evaluate (or first-push) state to the result state; a merging span goes
//   through evaluate, one merge step per span absorbed below the top, a push
//   step and the result state, with one registered read of the stack memory
//   per absorb step. s_tready rises together with m_tvalid.
// Reset (rst, synchronous): empties the stack and drops any pending result.
// Stall: a result held by m_tready low keeps the next span in its result phase
// until the output register frees up; s_tready stays low meanwhile.
module span_shift_reduce_stack #(
  parameter  int STACK_DEPTH = ssr_pkg::STACK_DEPTH_DEF,
  localparam int CW          = $clog2(STACK_DEPTH + 1),
  localparam int OW          = ((ssr_pkg::DIST_W + CW + 1 + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [2*ssr_pkg::POS_W-1:0] s_tdata,   // span_start, span_end
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [OW-1:0]               m_tdata    // distance, stack_depth, overflow
);

  localparam int PW = ssr_pkg::POS_W;
  localparam int DW = ssr_pkg::DIST_W;

  ssr_pkg::ssr_cmd_t  cmd;
  ssr_pkg::ssr_stat_t stat;

  logic signed [DW-1:0] distance;
  logic [CW-1:0]        stack_depth;
  logic                 overflow;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssr_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_start     (s_tdata[PW-1:0]),
    .in_end       (s_tdata[2*PW-1:PW]),
    .cmd          (cmd),
    .stat         (stat),
    .res_distance (distance),
    .res_depth    (stack_depth),
    .res_overflow (overflow)
  );

  assign m_tdata = OW'({overflow, stack_depth, distance});

endmodule

// File: verif/tb_top.sv
// Testbench for span_shift_reduce_stack: drives spans into the stream input and checks
// every result against a shift-reduce stack predictor kept in the bench.
// Depends on ssr_pkg and the span_shift_reduce_stack RTL.
module tb_top;

  localparam int POS_W       = ssr_pkg::POS_W;
  localparam int DIST_W      = ssr_pkg::DIST_W;
  localparam int STACK_DEPTH = ssr_pkg::STACK_DEPTH_DEF;
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int OW          = ((DIST_W + CW + 1 + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct {
    int lo;
    int hi;
  } span_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CW-1:0]     depth;
    logic              overflow;
  } step_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [2*POS_W-1:0] s_tdata;   // span_start, span_end
  logic              m_tvalid;
  logic              m_tready;
  logic [OW-1:0]     m_tdata;    // distance, stack_depth, overflow

  span_t        span_stk[STACK_DEPTH];
  int           span_cnt = 0;
  step_result_t expected_steps[$];
  int           fail_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  bit           hold_req = 1'b0;
  int           idle_cycles = 0;

  span_shift_reduce_stack dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(40, 15);
    return $urandom_range(3, 1);
  endfunction

  function automatic int jump_from_top(int st, int en);
    span_t t;
    if (span_cnt == 0) return st + 1;
    t = span_stk[span_cnt-1];
    if (st > t.lo) return st - t.hi;
    return en - t.lo;
  endfunction

  function automatic step_result_t shift_reduce(int st, int en);
    step_result_t r;
    span_t        cur;
    span_t        blw;
    int           d;
    r.overflow = 1'b0;
    d = jump_from_top(st, en);
    if (span_cnt == 0) begin
      span_stk[0] = '{st, en};
      span_cnt = 1;
    end else if (d == 1 || d == -1) begin
      cur = span_stk[span_cnt-1];
      span_cnt--;
      if (d == 1) cur.hi = en;
      else cur.lo = st;
      // keep absorbing neighbors below while they abut
      while (span_cnt > 0) begin
        blw = span_stk[span_cnt-1];
        if (cur.lo - blw.hi == 1) begin
          cur.lo = blw.lo;
          span_cnt--;
        end else if (blw.lo - cur.hi == 1) begin
          cur.hi = blw.hi;
          span_cnt--;
        end else begin
          break;
        end
      end
      span_stk[span_cnt] = cur;
      span_cnt++;
    end else if (span_cnt >= STACK_DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      span_stk[span_cnt] = '{st, en};
      span_cnt++;
    end
    r.distance = d[DIST_W-1:0];
    r.depth    = span_cnt[CW-1:0];
    return r;
  endfunction

  // Call at a rising edge; returns at the edge where the span was taken, tvalid still high.
  task automatic send_span(input logic [POS_W-1:0] st, input logic [POS_W-1:0] en);
    int gap;
    gap = (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {en, st};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_steps.insert(expected_steps.size(), shift_reduce(st, en));
  endtask

  // Span clear of the top, so it is pushed unchanged.
  task automatic send_far_span();
    int st;
    int en;
    int d;
    do begin
      st = $urandom_range(255);
      en = st + $urandom_range(5);
      if (en > 255) en = 255;
      d = jump_from_top(st, en);
    end while (d == 1 || d == -1);
    send_span(st[POS_W-1:0], en[POS_W-1:0]);
  endtask

  // Mix of well-formed phrase moves (monotone, swap, gap fill) with far jumps and noise.
  task automatic send_random_span();
    int    st;
    int    en;
    int    sel;
    int    w;
    span_t t;
    span_t b;
    sel = $urandom_range(99);
    w   = $urandom_range(3);
    st  = $urandom_range(255);
    en  = st + w;
    if (sel < 15) begin
      st = $urandom_range(255);
      en = $urandom_range(255);
    end else if (span_cnt > 0) begin
      t = span_stk[span_cnt-1];
      b = (span_cnt > 1) ? span_stk[span_cnt-2] : t;
      if (span_cnt > 1 && sel < 15 + 4 * span_cnt && b.hi + 1 < t.lo) begin
        st = b.hi + 1;
        en = t.lo - 1;
      end else if (span_cnt > 1 && sel < 15 + 4 * span_cnt && t.hi + 1 < b.lo) begin
        st = t.hi + 1;
        en = b.lo - 1;
      end else if (sel < 60) begin
        st = t.hi + 1;
        en = st + w;
      end else if (sel < 85) begin
        en = t.lo - 1;
        st = en - w;
      end
    end
    send_span(st[POS_W-1:0], en[POS_W-1:0]);
  endtask

  task automatic test_empty_stack_extremes();
    send_span(8'd255, 8'd0);   // first push, largest distance, reversed span
    send_span(8'd0, 8'd0);     // most negative distance
    send_span(8'd0, 8'd255);
    send_span(8'd255, 8'd255);
  endtask

  task automatic test_monotone_swap_merges();
    send_span(8'd0, 8'd2);
    send_span(8'd1, 8'd3);
    send_span(8'd4, 8'd5);     // not adjacent, pushed
    send_span(8'd10, 8'd12);
    send_span(8'd7, 8'd9);     // swap
    send_span(8'd6, 8'd6);     // swap, then absorb below
    send_span(8'd60, 8'd55);   // reversed, pushed
  endtask

  task automatic test_chained_absorb();
    send_span(8'd80, 8'd81);
    send_span(8'd90, 8'd92);
    send_span(8'd86, 8'd88);
    send_span(8'd89, 8'd89);   // monotone, absorbs on the end side
    send_span(8'd82, 8'd85);   // swap, absorbs on the start side
    send_span(8'd61, 8'd79);
  endtask

  task automatic test_full_stack();
    while (span_cnt < STACK_DEPTH) send_far_span();
    send_far_span();           // dropped, overflow set
    send_span(span_stk[span_cnt-1].hi[POS_W-1:0] + 8'd1,
              span_stk[span_cnt-1].hi[POS_W-1:0] + 8'd2);
    send_far_span();
  endtask

  task automatic test_output_backpressure();
    int i;
    tx_idle_pct = 0;
    hold_req = 1'b1;
    for (i = 0; i < 10; i++) send_random_span();
  endtask

  task automatic test_random_spans(input int count, input int tx_pct, input int rx_pct);
    int i;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (i = 0; i < count; i++) send_random_span();
  endtask

  // Receiver: idle at random, or hold off for a long stretch on request.
  initial begin : rx_ready
    int gap;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        gap = pick_gap();
        m_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    step_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_steps.size() == 0) begin
        $error("result with no span pending: tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_steps.pop_front();
        if (m_tdata[DIST_W-1:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", $signed(want.distance),
                 $signed(m_tdata[DIST_W-1:0]));
          fail_count++;
        end
        if (m_tdata[DIST_W+CW-1:DIST_W] !== want.depth) begin
          $error("stack_depth: expected %0d, got %0d", want.depth,
                 m_tdata[DIST_W+CW-1:DIST_W]);
          fail_count++;
        end
        if (m_tdata[DIST_W+CW] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_tdata[DIST_W+CW]);
          fail_count++;
        end
      end
    end
  end

  // End the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    test_empty_stack_extremes();
    test_monotone_swap_merges();
    test_chained_absorb();
    test_full_stack();
    test_random_spans(150, 0, 0);
    test_output_backpressure();
    test_random_spans(300, 30, 30);
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
